### hdl/macd_pkg.sv
// shared types and constants of the convergence/divergence histogram block
`default_nettype none
package macd_pkg;

   localparam int AVG_WIDTH = 50;
   localparam int CFG_WIDTH = 6;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHORT  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIGNAL = 2'd2;

   localparam logic [CFG_WIDTH-1:0] SHORT_RESET  = 6'd12;
   localparam logic [CFG_WIDTH-1:0] LONG_RESET   = 6'd26;
   localparam logic [CFG_WIDTH-1:0] SIGNAL_RESET = 6'd9;

   typedef enum logic [1:0] {
      TGT_FAST,
      TGT_SLOW,
      TGT_SIGNAL
   } tgt_type;

   typedef enum logic {
      DIV_MEAN,
      DIV_EMA
   } mode_type;

   typedef struct packed {
      logic     lat_price;
      logic     mem_wr;
      logic     mem_rd;
      logic     mac_wr;
      logic     mac_rd;
      logic     x_from_mem;
      logic     x_from_price;
      logic     clr_sums;
      logic     acc_fast;
      logic     acc_slow;
      logic     acc_signal;
      logic     m_from_fs;
      logic     m_from_mem;
      logic     div_start;
      tgt_type  div_tgt;
      mode_type div_mode;
      logic     out_load;
      logic     out_last;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } stat_type;

endpackage
`default_nettype wire

### hdl/macd_signal_histogram.sv
// MACD line, signal line and histogram over a stream of Q16.16 prices
//
// Prices enter on the req_ stream (price in tdata, series start flag in tuser).
// Results leave on the rsp_ stream; tlast marks the final result of a price.
// Period registers are written over the csr_ channel (index 0 short, 1 long,
// 2 signal); a write restarts the series. One price is handled at a time.
// The first W = max(periods) prices of a series are stored; the W-th price
// replays them and W results follow. Afterwards each price gives one result.
// Every divide (seed means and average updates) runs through one restoring
// divider of SW = 50 + log2(MAX_PERIOD) + 2 bits (57 by default); a divide
// holds the sequencer until the divider is done.
// Warm-up: each of the first W prices is stored. The W-th price then sums
// the first max(short, long) stored entries for the seed sums, replays all
// W entries and gives W results, with one divide per seed mean and per
// average update.
// A stalled rsp side holds the result in its register and the block waits.
// Reset restores periods 12, 26, 9 and empties the series; no clearing pass.
`default_nettype none
module macd_signal_histogram #(
   parameter int MAX_PERIOD  = 32,
   parameter int PRICE_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // price
   input  wire logic [((PRICE_WIDTH+7)/8)*8-1:0]     req_tdata,
   // first
   input  wire logic                                 req_tuser,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // macd_value, signal_line, histogram_value
   output logic [((3*PRICE_WIDTH+4+7)/8)*8-1:0]      rsp_tdata,
   output logic                                      rsp_tlast,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [macd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [macd_pkg::CFG_WIDTH-1:0]       csr_wdata
);

   localparam int IW  = $clog2(MAX_PERIOD + 1);
   localparam int TDW = ((3 * PRICE_WIDTH + 4 + 7) / 8) * 8;

   macd_pkg::cmd_type             cmd;
   macd_pkg::stat_type            stat;
   logic [IW-1:0]                 idx;
   logic [IW-1:0]                 ps;
   logic [IW-1:0]                 pl;
   logic [IW-1:0]                 pg;
   logic signed [PRICE_WIDTH:0]   macd_value;
   logic signed [PRICE_WIDTH:0]   signal_line;
   logic signed [PRICE_WIDTH+1:0] histogram_value;

   macd_ctrl #(
      .MAX_PERIOD(MAX_PERIOD)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_first (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .cmd       (cmd),
      .idx       (idx),
      .ps        (ps),
      .pl        (pl),
      .pg        (pg)
   );

   macd_datapath #(
      .MAX_PERIOD (MAX_PERIOD),
      .PRICE_WIDTH(PRICE_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .idx            (idx),
      .ps             (ps),
      .pl             (pl),
      .pg             (pg),
      .price_in       (req_tdata[PRICE_WIDTH-1:0]),
      .stat           (stat),
      .macd_value     (macd_value),
      .signal_line    (signal_line),
      .histogram_value(histogram_value),
      .last           (rsp_tlast)
   );

   assign rsp_tdata = TDW'({histogram_value, signal_line, macd_value});

endmodule
`default_nettype wire

### hdl/macd_div.sv
// rounded signed divide by a small unsigned divisor, one quotient bit per cycle
`default_nettype none
module macd_div #(
   parameter int NUM_WIDTH = 58,
   parameter int DEN_WIDTH = 7
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic signed [NUM_WIDTH-1:0] num,
   input  wire logic        [DEN_WIDTH-1:0] den,
   output logic                             done,
   output logic signed      [NUM_WIDTH-1:0] quo
);

   localparam int CW = $clog2(NUM_WIDTH + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic                 neg_ff;
   logic [NUM_WIDTH-1:0] dvd_ff;
   logic [DEN_WIDTH-1:0] rem_ff;
   logic [DEN_WIDTH-1:0] den_ff;
   logic [CW-1:0]        cnt_ff;
   logic [NUM_WIDTH-1:0] mag_in;
   logic [DEN_WIDTH:0]   rem_sh;
   logic [DEN_WIDTH:0]   rem_sub;
   logic                 qbit;
   logic [DEN_WIDTH-1:0] rem_in;

   always_comb begin
      mag_in  = (num < 0) ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
      mag_in  = mag_in + NUM_WIDTH'(den >> 1);
      rem_sh  = {rem_ff, dvd_ff[NUM_WIDTH-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      qbit    = (rem_sh >= {1'b0, den_ff});
      rem_in  = qbit ? rem_sub[DEN_WIDTH-1:0] : rem_sh[DEN_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         dvd_ff <= mag_in;
         rem_ff <= '0;
         den_ff <= den;
         neg_ff <= (num < 0);
         cnt_ff <= CW'(NUM_WIDTH);
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[NUM_WIDTH-2:0], qbit};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -$signed(dvd_ff) : $signed(dvd_ff);

endmodule
`default_nettype wire

### hdl/macd_datapath.sv
// averages, warm-up stores, shared divider and result register
`default_nettype none
module macd_datapath #(
   parameter int MAX_PERIOD  = 32,
   parameter int PRICE_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire macd_pkg::cmd_type                 cmd,
   input  wire logic [$clog2(MAX_PERIOD+1)-1:0]   idx,
   input  wire logic [$clog2(MAX_PERIOD+1)-1:0]   ps,
   input  wire logic [$clog2(MAX_PERIOD+1)-1:0]   pl,
   input  wire logic [$clog2(MAX_PERIOD+1)-1:0]   pg,
   input  wire logic [PRICE_WIDTH-1:0]            price_in,
   output macd_pkg::stat_type                     stat,
   output logic signed [PRICE_WIDTH:0]            macd_value,
   output logic signed [PRICE_WIDTH:0]            signal_line,
   output logic signed [PRICE_WIDTH+1:0]          histogram_value,
   output logic                                   last
);

   localparam int IW  = $clog2(MAX_PERIOD + 1);
   localparam int AW  = $clog2(MAX_PERIOD);
   localparam int G   = macd_pkg::AVG_WIDTH - PRICE_WIDTH;
   localparam int SW  = macd_pkg::AVG_WIDTH + $clog2(MAX_PERIOD) + 2;
   localparam int OW  = PRICE_WIDTH + 2;

   logic [PRICE_WIDTH-1:0] price_mem [MAX_PERIOD];
   logic signed [SW-1:0]   mac_mem   [MAX_PERIOD];

   logic [PRICE_WIDTH-1:0] price_ff;
   logic [PRICE_WIDTH-1:0] rdata_ff;
   logic signed [SW-1:0]   mdata_ff;
   logic signed [SW-1:0]   x_ff;
   logic signed [SW-1:0]   m_ff;
   logic signed [SW-1:0]   f_ff;
   logic signed [SW-1:0]   s_ff;
   logic signed [SW-1:0]   g_ff;
   logic signed [SW-1:0]   sum_f_ff;
   logic signed [SW-1:0]   sum_s_ff;
   logic signed [SW-1:0]   sum_g_ff;
   macd_pkg::tgt_type      tgt_ff;
   macd_pkg::mode_type     mode_ff;
   logic signed [OW-1:0]   mq_ff;
   logic signed [OW-1:0]   sq_ff;
   logic                   last_ff;

   logic signed [SW-1:0]   avg_sel;
   logic signed [SW-1:0]   in_sel;
   logic signed [SW-1:0]   sum_sel;
   logic [IW-1:0]          per_sel;
   logic signed [SW-1:0]   div_num;
   logic [IW:0]            div_den;
   logic                   div_done;
   logic signed [SW-1:0]   div_quo;
   logic signed [SW-1:0]   new_val;
   logic signed [OW-1:0]   mq_in;
   logic signed [OW-1:0]   sq_in;
   logic [AW-1:0]          addr;

   function automatic logic signed [OW-1:0] to_q(input logic signed [SW-1:0] v);
      logic [SW-1:0] mag;
      logic [SW-1:0] rq;
      mag = (v < 0) ? SW'(-v) : SW'(v);
      rq  = (mag + (SW'(1) << (G - 1))) >> G;
      return (v < 0) ? -$signed(rq[OW-1:0]) : $signed(rq[OW-1:0]);
   endfunction

   assign addr = idx[AW-1:0];

   always_comb begin
      unique case (cmd.div_tgt)
         macd_pkg::TGT_FAST: begin
            avg_sel = f_ff;
            in_sel  = x_ff;
            sum_sel = sum_f_ff;
            per_sel = ps;
         end
         macd_pkg::TGT_SLOW: begin
            avg_sel = s_ff;
            in_sel  = x_ff;
            sum_sel = sum_s_ff;
            per_sel = pl;
         end
         default: begin
            avg_sel = g_ff;
            in_sel  = m_ff;
            sum_sel = sum_g_ff;
            per_sel = pg;
         end
      endcase
      if (cmd.div_mode == macd_pkg::DIV_MEAN) begin
         div_num = sum_sel;
         div_den = {1'b0, per_sel};
      end else begin
         div_num = (in_sel - avg_sel) <<< 1;
         div_den = {1'b0, per_sel} + (IW+1)'(1);
      end
      unique case (tgt_ff)
         macd_pkg::TGT_FAST: new_val = f_ff;
         macd_pkg::TGT_SLOW: new_val = s_ff;
         default:            new_val = g_ff;
      endcase
      new_val = (mode_ff == macd_pkg::DIV_MEAN) ? div_quo : new_val + div_quo;
      mq_in = to_q(m_ff);
      sq_in = to_q(g_ff);
   end

   macd_div #(
      .NUM_WIDTH(SW),
      .DEN_WIDTH(IW + 1)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.div_start),
      .num  (div_num),
      .den  (div_den),
      .done (div_done),
      .quo  (div_quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         price_mem[addr] <= price_ff;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= price_mem[addr];
      end
      if (cmd.mac_wr) begin
         mac_mem[addr] <= m_ff;
      end
      if (cmd.mac_rd) begin
         mdata_ff <= mac_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ff     <= '0;
         s_ff     <= '0;
         g_ff     <= '0;
         sum_f_ff <= '0;
         sum_s_ff <= '0;
         sum_g_ff <= '0;
         tgt_ff   <= macd_pkg::TGT_FAST;
         mode_ff  <= macd_pkg::DIV_MEAN;
      end else begin
         if (cmd.clr_sums) begin
            sum_f_ff <= '0;
            sum_s_ff <= '0;
            sum_g_ff <= '0;
         end
         if (cmd.acc_fast) begin
            sum_f_ff <= sum_f_ff + x_ff;
         end
         if (cmd.acc_slow) begin
            sum_s_ff <= sum_s_ff + x_ff;
         end
         if (cmd.acc_signal) begin
            sum_g_ff <= sum_g_ff + m_ff;
         end
         if (cmd.div_start) begin
            tgt_ff  <= cmd.div_tgt;
            mode_ff <= cmd.div_mode;
         end
         if (div_done) begin
            unique case (tgt_ff)
               macd_pkg::TGT_FAST: f_ff <= new_val;
               macd_pkg::TGT_SLOW: s_ff <= new_val;
               default:            g_ff <= new_val;
            endcase
         end
      end
      if (cmd.lat_price) begin
         price_ff <= price_in;
      end
      if (cmd.x_from_mem) begin
         x_ff <= $signed(SW'({rdata_ff, {G{1'b0}}}));
      end
      if (cmd.x_from_price) begin
         x_ff <= $signed(SW'({price_ff, {G{1'b0}}}));
      end
      if (cmd.m_from_fs) begin
         m_ff <= f_ff - s_ff;
      end
      if (cmd.m_from_mem) begin
         m_ff <= mdata_ff;
      end
      if (cmd.out_load) begin
         mq_ff   <= mq_in;
         sq_ff   <= sq_in;
         last_ff <= cmd.out_last;
      end
   end

   assign stat.div_done    = div_done;
   assign macd_value       = mq_ff[PRICE_WIDTH:0];
   assign signal_line      = sq_ff[PRICE_WIDTH:0];
   assign histogram_value  = mq_ff - sq_ff;
   assign last             = last_ff;

endmodule
`default_nettype wire

### hdl/macd_ctrl.sv
// sequencer: period registers, warm-up count, replay and steady-state steps
`default_nettype none
module macd_ctrl #(
   parameter int MAX_PERIOD = 32
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   input  wire logic                                     req_first,
   output logic                                          rsp_tvalid,
   input  wire logic                                     rsp_tready,
   input  wire logic                                     csr_valid,
   output logic                                          csr_ready,
   input  wire logic [macd_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [macd_pkg::CFG_WIDTH-1:0]           csr_wdata,
   input  wire macd_pkg::stat_type                       stat,
   output macd_pkg::cmd_type                             cmd,
   output logic [$clog2(MAX_PERIOD+1)-1:0]               idx,
   output logic [$clog2(MAX_PERIOD+1)-1:0]               ps,
   output logic [$clog2(MAX_PERIOD+1)-1:0]               pl,
   output logic [$clog2(MAX_PERIOD+1)-1:0]               pg
);

   localparam int IW = $clog2(MAX_PERIOD + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_STORE, S_SEED, S_SEED_RD, S_SEED_X, S_SEED_ACC, S_MEAN_F, S_MEAN_S,
      S_RUN_RD, S_RUN_X, S_RUN_F, S_RUN_S, S_RUN_M, S_RUN_W, S_MEAN_G,
      S_EM_RD, S_EM_M, S_EM_G, S_OUT, S_OUT_WAIT,
      S_ST_X, S_ST_F, S_ST_S, S_ST_M, S_ST_G, S_DIV_WAIT
   } state_type;

   state_type                  state_ff;
   state_type                  ret_ff;
   logic [IW-1:0]              idx_ff;
   logic [IW-1:0]              count_ff;
   logic                       rsp_valid_ff;
   logic [macd_pkg::CFG_WIDTH-1:0] short_ff;
   logic [macd_pkg::CFG_WIDTH-1:0] long_ff;
   logic [macd_pkg::CFG_WIDTH-1:0] signal_ff;

   logic [IW-1:0] w;
   logic [IW-1:0] pfs;
   logic [IW-1:0] cnt_eff;
   logic [IW:0]   idx_nx;
   logic          at_last;

   function automatic logic [IW-1:0] eff(input logic [macd_pkg::CFG_WIDTH-1:0] r);
      logic [IW-1:0] p;
      if (r == '0) begin
         p = IW'(1);
      end else if (32'(r) > MAX_PERIOD) begin
         p = IW'(MAX_PERIOD);
      end else begin
         p = IW'(r);
      end
      return p;
   endfunction

   always_comb begin
      ps      = eff(short_ff);
      pl      = eff(long_ff);
      pg      = eff(signal_ff);
      pfs     = (ps > pl) ? ps : pl;
      w       = (pfs > pg) ? pfs : pg;
      cnt_eff = req_first ? '0 : count_ff;
      idx_nx  = {1'b0, idx_ff} + (IW+1)'(1);
      at_last = (idx_nx == {1'b0, w});
   end

   always_comb begin
      cmd          = '0;
      cmd.div_tgt  = macd_pkg::TGT_FAST;
      cmd.div_mode = macd_pkg::DIV_EMA;
      unique case (state_ff)
         S_IDLE:     cmd.lat_price = 1'b1;
         S_STORE:    cmd.mem_wr = 1'b1;
         S_SEED:     cmd.clr_sums = 1'b1;
         S_SEED_RD:  cmd.mem_rd = 1'b1;
         S_SEED_X:   cmd.x_from_mem = 1'b1;
         S_SEED_ACC: begin
            cmd.acc_fast = (idx_ff < ps);
            cmd.acc_slow = (idx_ff < pl);
         end
         S_MEAN_F: begin
            cmd.div_start = 1'b1;
            cmd.div_mode  = macd_pkg::DIV_MEAN;
         end
         S_MEAN_S: begin
            cmd.div_start = 1'b1;
            cmd.div_tgt   = macd_pkg::TGT_SLOW;
            cmd.div_mode  = macd_pkg::DIV_MEAN;
         end
         S_RUN_RD:   cmd.mem_rd = 1'b1;
         S_RUN_X:    cmd.x_from_mem = 1'b1;
         S_RUN_F:    cmd.div_start = (idx_ff >= ps);
         S_RUN_S: begin
            cmd.div_start = (idx_ff >= pl);
            cmd.div_tgt   = macd_pkg::TGT_SLOW;
         end
         S_RUN_M:    cmd.m_from_fs = 1'b1;
         S_RUN_W: begin
            cmd.mac_wr     = 1'b1;
            cmd.acc_signal = (idx_ff < pg);
         end
         S_MEAN_G: begin
            cmd.div_start = 1'b1;
            cmd.div_tgt   = macd_pkg::TGT_SIGNAL;
            cmd.div_mode  = macd_pkg::DIV_MEAN;
         end
         S_EM_RD:    cmd.mac_rd = 1'b1;
         S_EM_M:     cmd.m_from_mem = 1'b1;
         S_EM_G: begin
            cmd.div_start = (idx_ff >= pg);
            cmd.div_tgt   = macd_pkg::TGT_SIGNAL;
         end
         S_OUT: begin
            cmd.out_load = 1'b1;
            cmd.out_last = at_last;
         end
         S_ST_X:     cmd.x_from_price = 1'b1;
         S_ST_F:     cmd.div_start = 1'b1;
         S_ST_S: begin
            cmd.div_start = 1'b1;
            cmd.div_tgt   = macd_pkg::TGT_SLOW;
         end
         S_ST_M:     cmd.m_from_fs = 1'b1;
         S_ST_G: begin
            cmd.div_start = 1'b1;
            cmd.div_tgt   = macd_pkg::TGT_SIGNAL;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         short_ff     <= macd_pkg::SHORT_RESET;
         long_ff      <= macd_pkg::LONG_RESET;
         signal_ff    <= macd_pkg::SIGNAL_RESET;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  if (cnt_eff < w) begin
                     idx_ff   <= cnt_eff;
                     state_ff <= S_STORE;
                  end else begin
                     idx_ff   <= w - IW'(1);
                     state_ff <= S_ST_X;
                  end
               end
            end
            S_STORE: begin
               count_ff <= idx_nx[IW-1:0];
               state_ff <= at_last ? S_SEED : S_IDLE;
            end
            S_SEED: begin
               idx_ff   <= '0;
               state_ff <= S_SEED_RD;
            end
            S_SEED_RD:  state_ff <= S_SEED_X;
            S_SEED_X:   state_ff <= S_SEED_ACC;
            S_SEED_ACC: begin
               if (idx_nx < {1'b0, pfs}) begin
                  idx_ff   <= idx_nx[IW-1:0];
                  state_ff <= S_SEED_RD;
               end else begin
                  state_ff <= S_MEAN_F;
               end
            end
            S_MEAN_F: begin
               ret_ff   <= S_MEAN_S;
               state_ff <= S_DIV_WAIT;
            end
            S_MEAN_S: begin
               idx_ff   <= '0;
               ret_ff   <= S_RUN_RD;
               state_ff <= S_DIV_WAIT;
            end
            S_RUN_RD: state_ff <= S_RUN_X;
            S_RUN_X:  state_ff <= S_RUN_F;
            S_RUN_F: begin
               ret_ff   <= S_RUN_S;
               state_ff <= (idx_ff >= ps) ? S_DIV_WAIT : S_RUN_S;
            end
            S_RUN_S: begin
               ret_ff   <= S_RUN_M;
               state_ff <= (idx_ff >= pl) ? S_DIV_WAIT : S_RUN_M;
            end
            S_RUN_M:  state_ff <= S_RUN_W;
            S_RUN_W: begin
               if (at_last) begin
                  state_ff <= S_MEAN_G;
               end else begin
                  idx_ff   <= idx_nx[IW-1:0];
                  state_ff <= S_RUN_RD;
               end
            end
            S_MEAN_G: begin
               idx_ff   <= '0;
               ret_ff   <= S_EM_RD;
               state_ff <= S_DIV_WAIT;
            end
            S_EM_RD: state_ff <= S_EM_M;
            S_EM_M:  state_ff <= S_EM_G;
            S_EM_G: begin
               ret_ff   <= S_OUT;
               state_ff <= (idx_ff >= pg) ? S_DIV_WAIT : S_OUT;
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  if (at_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_nx[IW-1:0];
                     state_ff <= S_EM_RD;
                  end
               end
            end
            S_ST_X: state_ff <= S_ST_F;
            S_ST_F: begin
               ret_ff   <= S_ST_S;
               state_ff <= S_DIV_WAIT;
            end
            S_ST_S: begin
               ret_ff   <= S_ST_M;
               state_ff <= S_DIV_WAIT;
            end
            S_ST_M: state_ff <= S_ST_G;
            S_ST_G: begin
               ret_ff   <= S_OUT;
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (stat.div_done) begin
                  state_ff <= ret_ff;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (csr_valid) begin
            unique case (csr_index)
               macd_pkg::CSR_SHORT: begin
                  short_ff <= csr_wdata;
                  count_ff <= '0;
               end
               macd_pkg::CSR_LONG: begin
                  long_ff  <= csr_wdata;
                  count_ff <= '0;
               end
               macd_pkg::CSR_SIGNAL: begin
                  signal_ff <= csr_wdata;
                  count_ff  <= '0;
               end
               default: ;
            endcase
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign csr_ready  = 1'b1;
   assign idx        = idx_ff;

endmodule
`default_nettype wire
